>>> hdl/i2cras_pkg.sv
// ----------------------------------------------------------------------------
// i2cras_pkg
// Types and codes shared by the register access sequencer and its step logic.
// ----------------------------------------------------------------------------
package i2cras_pkg;

  // request opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_SENT  = 2'd2;
  localparam logic [1:0] OP_RECV  = 2'd3;

  // done status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NACK = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;
  localparam logic [1:0] ST_BUSY = 2'd3;

  // read/write bit of the address byte
  localparam logic [7:0] READ_BIT = 8'h01;

  // most results that one request can cause
  localparam int RES_MAX = 4;

  typedef enum logic [3:0] {
    K_START   = 4'd0,
    K_RESTART = 4'd1,
    K_WRITE   = 4'd2,
    K_READ    = 4'd3,
    K_ACK     = 4'd4,
    K_NACK    = 4'd5,
    K_STOP    = 4'd6,
    K_DATA    = 4'd7,
    K_DONE    = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ADDR    = 3'd1,
    PH_REG     = 3'd2,
    PH_LASTHDR = 3'd3,
    PH_DATA    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic [7:0] buffer_length;
    logic       ack_received;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] bus_byte;
    logic [7:0] byte_index;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    phase_t     phase;
    logic [6:0] slave_address;
    logic [7:0] register_address;
    logic [7:0] pending_data;
    logic       is_read;
    logic [7:0] bytes_total;
    logic [7:0] bytes_done;
  } state_t;

endpackage

>>> hdl/i2cras_step.sv
// ----------------------------------------------------------------------------
// i2cras_step
// Transaction step logic: from one request and the current transaction state,
// works out the next state and the list of bus commands and reports.
// ----------------------------------------------------------------------------
module i2cras_step (
  input  i2cras_pkg::item_t                         item_i,
  input  i2cras_pkg::state_t                        st_i,
  output i2cras_pkg::state_t                        st_nxt,
  output i2cras_pkg::res_t [i2cras_pkg::RES_MAX-1:0] res_o,
  output logic [2:0]                                num_o
);
  import i2cras_pkg::*;

  logic [7:0] addr_rd;
  logic [8:0] done_inc;

  // read address byte for the current slave
  assign addr_rd  = {st_i.slave_address, 1'b0} | READ_BIT;
  assign done_inc = {1'b0, st_i.bytes_done} + 9'd1;

  // result slot helper
  function automatic res_t mk(kind_t k, logic [7:0] b, logic [7:0] idx, logic [1:0] s);
    res_t r;
    r.kind       = k;
    r.bus_byte   = b;
    r.byte_index = idx;
    r.status     = s;
    return r;
  endfunction

  // step decode
  always_comb begin
    st_nxt = st_i;
    num_o  = 3'd0;
    for (int i = 0; i < RES_MAX; i++) begin
      res_o[i] = mk(K_START, 8'd0, 8'd0, ST_OK);
    end
    unique case (item_i.opcode)
      OP_WRITE, OP_READ: begin
        if (st_i.phase != PH_IDLE) begin
          res_o[0] = mk(K_DONE, 8'd0, 8'd0, ST_BUSY);
          num_o    = 3'd1;
        end else if (item_i.opcode == OP_READ &&
                     (item_i.read_count == 8'd0 ||
                      item_i.read_count != item_i.buffer_length)) begin
          res_o[0] = mk(K_DONE, 8'd0, 8'd0, ST_LEN);
          num_o    = 3'd1;
        end else begin
          st_nxt.slave_address    = item_i.dev_addr;
          st_nxt.register_address = item_i.reg_addr;
          st_nxt.pending_data     = (item_i.opcode == OP_WRITE) ? item_i.write_data : 8'd0;
          st_nxt.is_read          = (item_i.opcode == OP_READ);
          st_nxt.bytes_total      = (item_i.opcode == OP_READ) ? item_i.read_count : 8'd0;
          st_nxt.bytes_done       = 8'd0;
          st_nxt.phase            = PH_ADDR;
          res_o[0] = mk(K_START, 8'd0, 8'd0, ST_OK);
          res_o[1] = mk(K_WRITE, {item_i.dev_addr, 1'b0}, 8'd0, ST_OK);
          num_o    = 3'd2;
        end
      end
      OP_SENT: begin
        unique case (st_i.phase)
          PH_ADDR, PH_REG: begin
            if (!item_i.ack_received) begin
              st_nxt.phase = PH_IDLE;
              res_o[0] = mk(K_STOP, 8'd0, 8'd0, ST_OK);
              res_o[1] = mk(K_DONE, 8'd0, 8'd0, ST_NACK);
              num_o    = 3'd2;
            end else if (st_i.phase == PH_ADDR) begin
              st_nxt.phase = PH_REG;
              res_o[0] = mk(K_WRITE, st_i.register_address, 8'd0, ST_OK);
              num_o    = 3'd1;
            end else if (st_i.is_read) begin
              st_nxt.phase = PH_LASTHDR;
              res_o[0] = mk(K_RESTART, 8'd0, 8'd0, ST_OK);
              res_o[1] = mk(K_WRITE, addr_rd, 8'd0, ST_OK);
              num_o    = 3'd2;
            end else begin
              st_nxt.phase = PH_LASTHDR;
              res_o[0] = mk(K_WRITE, st_i.pending_data, 8'd0, ST_OK);
              num_o    = 3'd1;
            end
          end
          PH_LASTHDR: begin
            // ack of the last header byte is not checked
            if (st_i.is_read) begin
              st_nxt.phase      = PH_DATA;
              st_nxt.bytes_done = 8'd0;
              res_o[0] = mk(K_READ, 8'd0, 8'd0, ST_OK);
              num_o    = 3'd1;
            end else begin
              st_nxt.phase = PH_IDLE;
              res_o[0] = mk(K_STOP, 8'd0, 8'd0, ST_OK);
              res_o[1] = mk(K_DONE, 8'd0, 8'd0, ST_OK);
              num_o    = 3'd2;
            end
          end
          default: begin
            // stray byte-sent event
          end
        endcase
      end
      OP_RECV: begin
        if (st_i.phase == PH_DATA) begin
          res_o[0]          = mk(K_DATA, item_i.rx_byte, st_i.bytes_done, ST_OK);
          st_nxt.bytes_done = done_inc[7:0];
          if (done_inc >= {1'b0, st_i.bytes_total}) begin
            st_nxt.phase = PH_IDLE;
            res_o[1] = mk(K_NACK, 8'd0, 8'd0, ST_OK);
            res_o[2] = mk(K_STOP, 8'd0, 8'd0, ST_OK);
            res_o[3] = mk(K_DONE, 8'd0, 8'd0, ST_OK);
            num_o    = 3'd4;
          end else begin
            res_o[1] = mk(K_ACK, 8'd0, 8'd0, ST_OK);
            res_o[2] = mk(K_READ, 8'd0, 8'd0, ST_OK);
            num_o    = 3'd3;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/i2c_register_access_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_register_access_sequencer
// Sequences I2C register write and read transactions over a byte-level bus
// engine, turning host requests and engine events into bus commands.
// ----------------------------------------------------------------------------
// timing: a request is registered in item_r on acceptance, then its results
//   go to res_r and are presented one per cycle while out_stall is low
// throughput: one request per cycle while each causes at most one result and
//   out_stall is low; a request with more holds res_r until its last is taken
// reset: synchronous active-low rst_n clears the transaction state to idle
//   and empties the request and result registers
module i2c_register_access_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [6:0] in_dev_addr,
  input  logic [7:0] in_reg_addr,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_read_count,
  input  logic [7:0] in_buffer_length,
  input  logic       in_ack_received,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_kind,
  output logic [7:0] out_bus_byte,
  output logic [7:0] out_byte_index,
  output logic [1:0] out_status,
  output logic       out_last
);
  import i2cras_pkg::*;

  item_t                 item_r;
  logic                  item_v_r;
  state_t                state_r;
  state_t                st_nxt;
  res_t [RES_MAX-1:0]    res_r;
  res_t [RES_MAX-1:0]    res_nxt;
  logic [2:0]            num_r;
  logic [2:0]            num_nxt;
  logic [1:0]            ptr_r;
  logic                  in_take;
  logic                  out_take;
  logic                  last_take;
  logic                  advance;

  // handshake
  assign out_valid = (num_r != 3'd0);
  assign out_last  = out_valid && ({1'b0, ptr_r} == (num_r - 3'd1));
  assign out_take  = out_valid && !out_stall;
  assign last_take = out_take && out_last;
  assign advance   = item_v_r && (num_r == 3'd0 || last_take);
  assign in_stall  = item_v_r && !advance;
  assign in_take   = in_valid && !in_stall;

  // result fields
  assign out_kind       = res_r[ptr_r].kind;
  assign out_bus_byte   = res_r[ptr_r].bus_byte;
  assign out_byte_index = res_r[ptr_r].byte_index;
  assign out_status     = res_r[ptr_r].status;

  // step logic between request register and result buffer
  i2cras_step u_step (
    .item_i (item_r),
    .st_i   (state_r),
    .st_nxt (st_nxt),
    .res_o  (res_nxt),
    .num_o  (num_nxt)
  );

  // request payload register
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= '{opcode: in_opcode, dev_addr: in_dev_addr,
                  reg_addr: in_reg_addr, write_data: in_write_data,
                  read_count: in_read_count, buffer_length: in_buffer_length,
                  ack_received: in_ack_received, rx_byte: in_rx_byte};
    end
  end

  // result payload buffer
  always_ff @(posedge clk) begin
    if (advance && num_nxt != 3'd0) begin
      res_r <= res_nxt;
    end
  end

  // control and transaction state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      num_r    <= 3'd0;
      ptr_r    <= 2'd0;
      state_r  <= '{phase: PH_IDLE, default: '0};
    end else begin
      if (in_take) begin
        item_v_r <= 1'b1;
      end else if (advance) begin
        item_v_r <= 1'b0;
      end
      if (advance) begin
        state_r <= st_nxt;
        num_r   <= num_nxt;
        ptr_r   <= 2'd0;
      end else if (last_take) begin
        num_r <= 3'd0;
        ptr_r <= 2'd0;
      end else if (out_take) begin
        ptr_r <= ptr_r + 2'd1;
      end
    end
  end

  // checks
  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, ptr_r} < num_r))
    else $error("result pointer beyond buffer fill");

  a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
    num_r <= 3'd4)
    else $error("result buffer overfilled");

  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == K_DONE && out_status == ST_BUSY) |-> out_last)
    else $error("busy status not sole result of its request");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_v_r && out_valid))
    else $error("request stalled with nothing pending");

endmodule

>>> sim/i2c_register_access_sequencer_tb.sv
// ----------------------------------------------------------------------------
// i2c_register_access_sequencer_tb
// Drives host write/read requests and bus engine events into the sequencer
// and checks every bus command it issues. A directed table covers stray
// events, length errors, busy requests and nacks on the address, register and data bytes. A
// random part follows, with mostly well-formed transactions and some noise.
// Each request is run through a local model of the transaction state, and
// every result is compared field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module i2c_register_access_sequencer_tb;
  import i2cras_pkg::*;

  localparam int RANDOM_ITEMS = 96;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_LIMIT   = 1000;
  localparam int N_DIRECTED   = 24;

  // one bus command as seen on the result channel
  typedef struct packed {
    kind_t      kind;
    logic [7:0] bus_byte;
    logic [7:0] byte_index;
    logic [1:0] status;
    logic       last;
  } cmd_t;

  // one row of the directed table; fixed rows carry their own outcome
  typedef struct packed {
    logic [1:0] op;
    logic [6:0] dev;
    logic [7:0] reg_addr;
    logic [7:0] wdat;
    logic [7:0] cnt;
    logic [7:0] blen;
    logic       ack;
    logic [7:0] rx;
    logic       fixed;
    logic       fixed_done;
    logic [1:0] fixed_status;
  } step_row_t;

  localparam step_row_t DIRECTED_STEPS [N_DIRECTED] = '{
    // stray events while idle
    '{OP_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, ST_OK},
    '{OP_RECV, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0, ST_OK},
    // zero count and count/buffer mismatch
    '{OP_READ, 7'h11, 8'h22, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, ST_LEN},
    '{OP_READ, 7'h11, 8'h22, 8'h00, 8'hFF, 8'hFE, 1'b0, 8'h00, 1'b1, 1'b1, ST_LEN},
    // full write at the top of every field, busy requests in the middle
    '{OP_WRITE, 7'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{OP_WRITE, 7'h01, 8'h02, 8'h03, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, ST_BUSY},
    '{OP_READ, 7'h01, 8'h02, 8'h00, 8'h02, 8'h02, 1'b0, 8'h00, 1'b1, 1'b1, ST_BUSY},
    '{OP_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, ST_OK},
    '{OP_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, ST_OK},
    // nack on the data byte is not checked
    '{OP_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    // write at all zeros, nack on the address byte
    '{OP_WRITE, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{OP_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    // single byte read, nack on the register byte
    '{OP_READ, 7'h55, 8'h80, 8'h00, 8'h01, 8'h01, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{OP_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, ST_OK},
    '{OP_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    // three byte read with stray events on the way
    '{OP_READ, 7'h2A, 8'h12, 8'h00, 8'h03, 8'h03, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{OP_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, ST_OK},
    '{OP_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, ST_OK},
    '{OP_RECV, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h5A, 1'b1, 1'b0, ST_OK},
    '{OP_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{OP_SENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, ST_OK},
    '{OP_RECV, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'hFF, 1'b0, 1'b0, ST_OK},
    '{OP_RECV, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{OP_RECV, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'hA5, 1'b0, 1'b0, ST_OK}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_opcode = OP_WRITE;
  logic [6:0] in_dev_addr = 7'h00;
  logic [7:0] in_reg_addr = 8'h00;
  logic [7:0] in_write_data = 8'h00;
  logic [7:0] in_read_count = 8'h00;
  logic [7:0] in_buffer_length = 8'h00;
  logic       in_ack_received = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] out_kind;
  logic [7:0] out_bus_byte;
  logic [7:0] out_byte_index;
  logic [1:0] out_status;
  logic       out_last;

  // local copy of the transaction state
  phase_t     seq_phase = PH_IDLE;
  logic [6:0] seq_dev = 7'h00;
  logic [7:0] seq_reg = 8'h00;
  logic [7:0] seq_wdata = 8'h00;
  logic       seq_is_read = 1'b0;
  logic [7:0] seq_total = 8'h00;
  logic [7:0] seq_count = 8'h00;

  cmd_t cmd_buf [RES_MAX];
  int   cmd_n;
  cmd_t bus_cmds_due [$];

  int errors = 0;
  int answered = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int idle_cycles = 0;

  i2c_register_access_sequencer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_dev_addr       (in_dev_addr),
    .in_reg_addr       (in_reg_addr),
    .in_write_data     (in_write_data),
    .in_read_count     (in_read_count),
    .in_buffer_length  (in_buffer_length),
    .in_ack_received   (in_ack_received),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_bus_byte      (out_bus_byte),
    .out_byte_index    (out_byte_index),
    .out_status        (out_status),
    .out_last          (out_last)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void push_cmd(kind_t k, logic [7:0] b, logic [7:0] idx,
                                   logic [1:0] st);
    cmd_buf[cmd_n] = '{kind: k, bus_byte: b, byte_index: idx, status: st, last: 1'b0};
    cmd_n++;
  endfunction

  function automatic logic [7:0] addr_byte(logic rd);
    return {seq_dev, 1'b0} | (rd ? READ_BIT : 8'h00);
  endfunction

  // bus commands caused by one request, advancing the transaction state
  function automatic void predict_bus_cmds(item_t r);
    cmd_n = 0;
    case (r.opcode)
      OP_WRITE, OP_READ: begin
        if (seq_phase != PH_IDLE) begin
          push_cmd(K_DONE, 8'h00, 8'h00, ST_BUSY);
        end else if (r.opcode == OP_READ &&
                     (r.read_count == 8'h00 || r.read_count != r.buffer_length)) begin
          push_cmd(K_DONE, 8'h00, 8'h00, ST_LEN);
        end else begin
          seq_dev     = r.dev_addr;
          seq_reg     = r.reg_addr;
          seq_wdata   = (r.opcode == OP_WRITE) ? r.write_data : 8'h00;
          seq_is_read = (r.opcode == OP_READ);
          seq_total   = seq_is_read ? r.read_count : 8'h00;
          seq_count   = 8'h00;
          seq_phase   = PH_ADDR;
          push_cmd(K_START, 8'h00, 8'h00, ST_OK);
          push_cmd(K_WRITE, addr_byte(1'b0), 8'h00, ST_OK);
        end
      end
      OP_SENT: begin
        case (seq_phase)
          PH_ADDR, PH_REG: begin
            if (!r.ack_received) begin
              seq_phase = PH_IDLE;
              push_cmd(K_STOP, 8'h00, 8'h00, ST_OK);
              push_cmd(K_DONE, 8'h00, 8'h00, ST_NACK);
            end else if (seq_phase == PH_ADDR) begin
              seq_phase = PH_REG;
              push_cmd(K_WRITE, seq_reg, 8'h00, ST_OK);
            end else if (seq_is_read) begin
              seq_phase = PH_LASTHDR;
              push_cmd(K_RESTART, 8'h00, 8'h00, ST_OK);
              push_cmd(K_WRITE, addr_byte(1'b1), 8'h00, ST_OK);
            end else begin
              seq_phase = PH_LASTHDR;
              push_cmd(K_WRITE, seq_wdata, 8'h00, ST_OK);
            end
          end
          // ack of the last header byte is ignored
          PH_LASTHDR: begin
            if (seq_is_read) begin
              seq_phase = PH_DATA;
              seq_count = 8'h00;
              push_cmd(K_READ, 8'h00, 8'h00, ST_OK);
            end else begin
              seq_phase = PH_IDLE;
              push_cmd(K_STOP, 8'h00, 8'h00, ST_OK);
              push_cmd(K_DONE, 8'h00, 8'h00, ST_OK);
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (seq_phase == PH_DATA) begin
          push_cmd(K_DATA, r.rx_byte, seq_count, ST_OK);
          if (int'(seq_count) + 1 >= int'(seq_total)) begin
            seq_phase = PH_IDLE;
            push_cmd(K_NACK, 8'h00, 8'h00, ST_OK);
            push_cmd(K_STOP, 8'h00, 8'h00, ST_OK);
            push_cmd(K_DONE, 8'h00, 8'h00, ST_OK);
          end else begin
            push_cmd(K_ACK, 8'h00, 8'h00, ST_OK);
            push_cmd(K_READ, 8'h00, 8'h00, ST_OK);
          end
          seq_count = seq_count + 8'd1;
        end
      end
    endcase
    if (cmd_n > 0) cmd_buf[cmd_n - 1].last = 1'b1;
  endfunction

  // present one request in bursts with random gaps, wait for it to be taken
  task automatic send_request(input item_t r, input logic fixed, input logic fixed_done,
                              input logic [1:0] fixed_status);
    int i;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    in_valid          <= 1'b1;
    in_opcode         <= r.opcode;
    in_dev_addr       <= r.dev_addr;
    in_reg_addr       <= r.reg_addr;
    in_write_data     <= r.write_data;
    in_read_count     <= r.read_count;
    in_buffer_length  <= r.buffer_length;
    in_ack_received   <= r.ack_received;
    in_rx_byte        <= r.rx_byte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    predict_bus_cmds(r);
    if (fixed) begin
      if (fixed_done)
        bus_cmds_due.push_back('{kind: K_DONE, bus_byte: 8'h00, byte_index: 8'h00,
                                 status: fixed_status, last: 1'b1});
    end else begin
      for (i = 0; i < cmd_n; i++) bus_cmds_due.push_back(cmd_buf[i]);
    end
    if (cmd_n > 0) answered++;
  endtask

  // receiver: runs of free flow, solid stall, random stall and toggling
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(1, 24);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'b1;
        2: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    cmd_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (bus_cmds_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing due, kind %0d", out_kind));
      end else begin
        due = bus_cmds_due.pop_front();
        if (out_kind !== due.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_kind, due.kind));
        if (out_bus_byte !== due.bus_byte)
          report_mismatch($sformatf("bus_byte %0h, want %0h", out_bus_byte, due.bus_byte));
        if (out_byte_index !== due.byte_index)
          report_mismatch($sformatf("byte_index %0d, want %0d", out_byte_index,
                                    due.byte_index));
        if (out_status !== due.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, due.status));
        if (out_last !== due.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, due.last));
      end
    end
  end

  // watchdog on cycles with no request and no result taken
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    item_t     r;
    step_row_t row;
    int        k;
    int        pick;
    logic      noise;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (k = 0; k < N_DIRECTED; k++) begin
      row = DIRECTED_STEPS[k];
      r.opcode         = row.op;
      r.dev_addr       = row.dev;
      r.reg_addr       = row.reg_addr;
      r.write_data     = row.wdat;
      r.read_count     = row.cnt;
      r.buffer_length  = row.blen;
      r.ack_received   = row.ack;
      r.rx_byte        = row.rx;
      send_request(r, row.fixed, row.fixed_done, row.fixed_status);
    end

    // random transactions steered by the current phase, with some noise
    answered = 0;
    while (answered < RANDOM_ITEMS) begin
      r.opcode         = 2'($urandom_range(0, 3));
      r.dev_addr       = 7'($urandom_range(0, 127));
      r.reg_addr       = 8'($urandom_range(0, 255));
      r.write_data     = 8'($urandom_range(0, 255));
      r.read_count     = 8'($urandom_range(0, 255));
      r.buffer_length  = 8'($urandom_range(0, 255));
      r.ack_received   = 1'($urandom_range(0, 1));
      r.rx_byte        = 8'($urandom_range(0, 255));
      noise = ($urandom_range(0, 9) == 0);
      case (seq_phase)
        PH_IDLE: begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            r.opcode = OP_WRITE;
          end else if (pick < 8) begin
            // mostly short reads, now and then a long one
            r.opcode = OP_READ;
            if ($urandom_range(0, 15) == 0)
              r.read_count = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(5, 254));
            else
              r.read_count = 8'($urandom_range(1, 4));
            r.buffer_length = r.read_count;
          end else if (pick < 9) begin
            r.opcode = OP_READ;
          end
        end
        PH_ADDR, PH_REG: begin
          if (!noise) begin
            r.opcode       = OP_SENT;
            r.ack_received = ($urandom_range(0, 7) != 0);
          end
        end
        PH_LASTHDR: if (!noise) r.opcode = OP_SENT;
        default:    if (!noise) r.opcode = OP_RECV;
      endcase
      send_request(r, 1'b0, 1'b0, ST_OK);
    end
    in_valid <= 1'b0;

    while (bus_cmds_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
